@@ rtl/core/pkec_pkg.sv @@
// Shared types and constants of the per-key energy-weighted centroid block.
`timescale 1ns / 1ps
package pkec_pkg;

	// Slot index as carried between front and back (covers up to 256 slots)
	localparam int unsigned SlotIdxW = 8;

	localparam logic [31:0] SignBit = 32'h8000_0000;
	localparam logic [31:0] Max32   = 32'hFFFF_FFFF;
	localparam logic [47:0] Max48   = 48'hFFFF_FFFF_FFFF;

	// Item actions
	localparam logic ActAdd   = 1'b0;
	localparam logic ActClear = 1'b1;

	// Classified item handed from front to back
	typedef struct packed {
		logic                clear;
		logic                full;
		logic                fresh;
		logic [SlotIdxW-1:0] slot;
		logic [31:0]         hit_total;
		logic [47:0]         energy_total;
		logic [31:0]         energy;
		logic [31:0]         pos_x;
		logic [31:0]         pos_y;
		logic [31:0]         pos_z;
	} job_t;

	// One result transaction
	typedef struct packed {
		logic [31:0] total_hits;
		logic [47:0] total_energy;
		logic [47:0] entry_energy;
		logic [31:0] entry_hits;
		logic [31:0] centroid_x;
		logic [31:0] centroid_y;
		logic [31:0] centroid_z;
		logic        table_full;
	} result_t;

	// Per-slot sums held in the back memory
	typedef struct packed {
		logic [47:0] energy;
		logic [31:0] hits;
		logic [31:0] cx;
		logic [31:0] cy;
		logic [31:0] cz;
	} slot_t;

endpackage

@@ rtl/core/per_key_energy_weighted_centroid.sv @@
// Per-key energy-weighted centroid accumulator, top level.
// Hits are pushed as queue writes and each item yields one result that is
// popped from a result queue. A front end keeps the hit and energy totals and
// matches each key against a table of SLOTS keys, allocating the lowest free
// slot for a new key; a two-entry queue decouples it from the back end, which
// reads the slot sums from memory, forms each axis numerator W*c + e*p on one
// shared 32x32 multiplier and divides it by W + e in a restoring divider. An
// add hit therefore passes through load, the multiply and divide phases of
// each of the three axes, write and emit (load goes straight to write when
// W + e is zero); a clear item or a hit refused by a full table goes straight
// to emit. The front accepts items in consecutive cycles until the job queue
// fills. No clearing pass is needed after reset.
`timescale 1ns / 1ps
module per_key_energy_weighted_centroid #(
	parameter int unsigned SLOTS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic               action,
	input  logic signed [31:0] particle_key,
	input  logic        [31:0] energy,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	output logic               empty,
	input  logic               pop,
	output logic        [31:0] total_hits,
	output logic        [47:0] total_energy,
	output logic        [47:0] entry_energy,
	output logic        [31:0] entry_hits,
	output logic signed [31:0] centroid_x,
	output logic signed [31:0] centroid_y,
	output logic signed [31:0] centroid_z,
	output logic               table_full
);
	import pkec_pkg::*;

	localparam int unsigned SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	job_t    job_in;
	job_t    job_out;
	logic    job_push;
	logic    job_full;
	logic    job_pop;
	logic    job_empty;
	result_t res_in;
	result_t res_out;
	logic    res_push;
	logic    res_full;

	assign full = job_full;

	pkec_front #(.SLOTS(SLOTS), .SLOT_W(SLOT_W)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.q_full       (job_full),
		.action       (action),
		.particle_key (particle_key),
		.energy       (energy),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.pos_z        (pos_z),
		.job_push     (job_push),
		.job          (job_in)
	);

	pkec_fifo #(.WIDTH($bits(job_t)), .DEPTH(2)) u_job_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (job_push),
		.wr_data (job_in),
		.full    (job_full),
		.pop     (job_pop),
		.rd_data (job_out),
		.empty   (job_empty)
	);

	pkec_back #(.SLOTS(SLOTS), .SLOT_W(SLOT_W)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_empty (job_empty),
		.job       (job_out),
		.job_pop   (job_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res_in)
	);

	pkec_fifo #(.WIDTH($bits(result_t)), .DEPTH(2)) u_res_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (res_push),
		.wr_data (res_in),
		.full    (res_full),
		.pop     (pop),
		.rd_data (res_out),
		.empty   (empty)
	);

	assign total_hits   = res_out.total_hits;
	assign total_energy = res_out.total_energy;
	assign entry_energy = res_out.entry_energy;
	assign entry_hits   = res_out.entry_hits;
	assign centroid_x   = res_out.centroid_x;
	assign centroid_y   = res_out.centroid_y;
	assign centroid_z   = res_out.centroid_z;
	assign table_full   = res_out.table_full;

	// back end never takes a transaction from an empty job queue
	a_job_pop: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |-> !job_empty) else $error("job pop while job queue empty");

	// back end never writes a result into a full result queue
	a_res_push: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full) else $error("result push while result queue full");

	// a clear transaction (zero totals and entry hits) reports zero entry energy
	a_clear_res: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && res_in.total_hits == '0 && !res_in.table_full
			&& res_in.entry_hits == '0) |-> (res_in.entry_energy == '0))
		else $error("clear result carries entry data");

endmodule

@@ rtl/core/pkec_fifo.sv @@
// Small synchronous queue used between front and back and at the result side.
`timescale 1ns / 1ps
module pkec_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);
	localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CntW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PtrW-1:0]  wr_ptr_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [CntW-1:0]  count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CntW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/core/pkec_front.sv @@
// Front end: takes items, keeps totals and the key table, assigns slots.
`timescale 1ns / 1ps
module pkec_front #(
	parameter int unsigned SLOTS  = 16,
	parameter int unsigned SLOT_W = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic                q_full,
	input  logic                action,
	input  logic signed [31:0]  particle_key,
	input  logic        [31:0]  energy,
	input  logic signed [31:0]  pos_x,
	input  logic signed [31:0]  pos_y,
	input  logic signed [31:0]  pos_z,
	output logic                job_push,
	output pkec_pkg::job_t      job
);
	import pkec_pkg::*;

	logic [31:0]       hit_total_q;
	logic [47:0]       energy_total_q;
	logic [SLOTS-1:0]  valid_q;
	logic [31:0]       key_q [SLOTS];

	logic              accept;
	logic              is_clear;
	logic              match_found;
	logic [SLOT_W-1:0] match_idx;
	logic              free_found;
	logic [SLOT_W-1:0] free_idx;
	logic [31:0]       hit_next;
	logic [48:0]       e_sum;
	logic [47:0]       energy_next;

	assign accept   = push && !q_full;
	assign job_push = accept;
	assign is_clear = (action == ActClear);

	// key match and lowest free slot
	always_comb begin
		match_found = 1'b0;
		match_idx   = '0;
		free_found  = 1'b0;
		free_idx    = '0;
		for (int i = 0; i < SLOTS; i++) begin
			if (!match_found && valid_q[i] && (key_q[i] == particle_key)) begin
				match_found = 1'b1;
				match_idx   = SLOT_W'(i);
			end
			if (!free_found && !valid_q[i]) begin
				free_found = 1'b1;
				free_idx   = SLOT_W'(i);
			end
		end
	end

	// saturating totals
	assign hit_next    = (hit_total_q == Max32) ? Max32 : hit_total_q + 32'd1;
	assign e_sum       = {1'b0, energy_total_q} + {17'b0, energy};
	assign energy_next = e_sum[48] ? Max48 : e_sum[47:0];

	// classified transaction
	always_comb begin
		job.clear        = is_clear;
		job.full         = !is_clear && !match_found && !free_found;
		job.fresh        = !match_found;
		job.slot         = match_found ? SlotIdxW'(match_idx) : SlotIdxW'(free_idx);
		job.hit_total    = is_clear ? '0 : hit_next;
		job.energy_total = is_clear ? '0 : energy_next;
		job.energy       = energy;
		job.pos_x        = pos_x;
		job.pos_y        = pos_y;
		job.pos_z        = pos_z;
	end

	// totals and slot valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_total_q    <= '0;
			energy_total_q <= '0;
			valid_q        <= '0;
		end else if (accept) begin
			if (is_clear) begin
				hit_total_q    <= '0;
				energy_total_q <= '0;
				valid_q        <= '0;
			end else begin
				hit_total_q    <= hit_next;
				energy_total_q <= energy_next;
				if (!match_found && free_found) begin
					valid_q[free_idx] <= 1'b1;
				end
			end
		end
	end

	// stored keys
	always_ff @(posedge clk) begin
		if (accept && !is_clear && !match_found && free_found) begin
			key_q[free_idx] <= particle_key;
		end
	end

endmodule

@@ rtl/core/pkec_div.sv @@
// Restoring divider: 81-bit numerator by 49-bit divisor, 32-bit quotient, one bit a cycle.
`timescale 1ns / 1ps
module pkec_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [81:0] num,
	input  logic [48:0] den,
	output logic        done,
	output logic [31:0] quo
);
	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [48:0] rem_q;
	logic [31:0] nlo_q;
	logic [31:0] quo_q;
	logic [48:0] den_q;
	logic [49:0] trial;
	logic [49:0] diff;
	logic        ge;

	assign done  = done_q;
	assign quo   = quo_q;
	assign trial = {rem_q, nlo_q[31]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = (trial >= {1'b0, den_q});

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath; upper numerator bits are below the divisor since the quotient fits 32 bits
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num[80:32];
			nlo_q <= num[31:0];
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[48:0] : trial[48:0];
			nlo_q <= {nlo_q[30:0], 1'b0};
			quo_q <= {quo_q[30:0], ge};
		end
	end

endmodule

@@ rtl/core/pkec_back.sv @@
// Back end: slot memory update, weighted sums on a shared multiplier and the divider.
`timescale 1ns / 1ps
module pkec_back #(
	parameter int unsigned SLOTS  = 16,
	parameter int unsigned SLOT_W = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 job_empty,
	input  pkec_pkg::job_t       job,
	output logic                 job_pop,
	input  logic                 res_full,
	output logic                 res_push,
	output pkec_pkg::result_t    res
);
	import pkec_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_LOAD  = 3'd1;
	localparam logic [2:0] S_MUL   = 3'd2;
	localparam logic [2:0] S_DIV   = 3'd3;
	localparam logic [2:0] S_WRITE = 3'd4;
	localparam logic [2:0] S_EMIT  = 3'd5;

	slot_t       mem [SLOTS];
	slot_t       rd_q;
	slot_t       new_slot;
	job_t        job_q;
	result_t     res_q;
	result_t     res_init;
	logic [2:0]  state_q;
	logic [47:0] w_q;
	logic [48:0] den_q;
	logic [47:0] ent_energy_q;
	logic [31:0] hits_q;
	logic [31:0] cent_q [3];
	logic [1:0]  axis_q;
	logic [1:0]  step_q;
	logic [63:0] prod_q;
	logic [81:0] acc_q;

	logic [47:0] w_ld;
	logic [48:0] den_ld;
	logic [31:0] hits_ld;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [31:0] pos_sel;
	logic        div_start;
	logic [81:0] div_num;
	logic        div_done;
	logic [31:0] div_quo;
	logic [SLOT_W-1:0] slot_idx;

	assign job_pop  = (state_q == S_IDLE) && !job_empty;
	assign res_push = (state_q == S_EMIT) && !res_full;
	assign res      = res_q;
	assign slot_idx = job_q.slot[SLOT_W-1:0];

	// sums before this hit; a fresh slot starts from zero
	assign w_ld    = job_q.fresh ? '0 : rd_q.energy;
	assign hits_ld = job_q.fresh ? '0 : rd_q.hits;
	assign den_ld  = {1'b0, w_ld} + {17'b0, job_q.energy};

	// multiplier operands: W low half, W high half, then hit energy
	always_comb begin
		unique case (axis_q)
			2'd0:    pos_sel = job_q.pos_x;
			2'd1:    pos_sel = job_q.pos_y;
			default: pos_sel = job_q.pos_z;
		endcase
		unique case (step_q)
			2'd0:    mul_a = w_q[31:0];
			2'd1:    mul_a = {16'b0, w_q[47:32]};
			default: mul_a = job_q.energy;
		endcase
		mul_b = (step_q < 2'd2) ? (cent_q[axis_q] ^ SignBit) : (pos_sel ^ SignBit);
	end

	assign div_start = (state_q == S_MUL) && (step_q == 2'd3);
	assign div_num   = acc_q + {18'b0, prod_q};

	pkec_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (den_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_comb begin
		new_slot.energy = ent_energy_q;
		new_slot.hits   = hits_q;
		new_slot.cx     = cent_q[0];
		new_slot.cy     = cent_q[1];
		new_slot.cz     = cent_q[2];
	end

	// result fields known at pop time; entry fields start at zero
	always_comb begin
		res_init              = '0;
		res_init.total_hits   = job.hit_total;
		res_init.total_energy = job.energy_total;
		res_init.table_full   = job.full;
	end

	// slot memory, registered read
	always_ff @(posedge clk) begin
		if (job_pop) begin
			rd_q <= mem[job.slot[SLOT_W-1:0]];
		end
		if (state_q == S_WRITE) begin
			mem[slot_idx] <= new_slot;
		end
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			axis_q  <= '0;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (job_pop) begin
						state_q <= (job.clear || job.full) ? S_EMIT : S_LOAD;
					end
				end
				S_LOAD: begin
					axis_q  <= '0;
					step_q  <= '0;
					state_q <= (den_ld == '0) ? S_WRITE : S_MUL;
				end
				S_MUL: begin
					step_q <= step_q + 2'd1;
					if (step_q == 2'd3) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						step_q <= '0;
						if (axis_q == 2'd2) begin
							state_q <= S_WRITE;
						end else begin
							axis_q  <= axis_q + 2'd1;
							state_q <= S_MUL;
						end
					end
				end
				S_WRITE: state_q <= S_EMIT;
				S_EMIT: begin
					if (!res_full) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (job_pop) begin
					job_q <= job;
					res_q <= res_init;
				end
			end
			S_LOAD: begin
				w_q          <= w_ld;
				den_q        <= den_ld;
				ent_energy_q <= den_ld[48] ? Max48 : den_ld[47:0];
				hits_q       <= (hits_ld == Max32) ? Max32 : hits_ld + 32'd1;
				cent_q[0]    <= job_q.fresh ? '0 : rd_q.cx;
				cent_q[1]    <= job_q.fresh ? '0 : rd_q.cy;
				cent_q[2]    <= job_q.fresh ? '0 : rd_q.cz;
				acc_q        <= {34'b0, den_ld[48:1]};
			end
			S_MUL: begin
				prod_q <= mul_a * mul_b;
				unique case (step_q)
					2'd1:    acc_q <= acc_q + {18'b0, prod_q};
					2'd2:    acc_q <= acc_q + {prod_q[49:0], 32'b0};
					default: acc_q <= acc_q;
				endcase
			end
			S_DIV: begin
				if (div_done) begin
					cent_q[axis_q] <= div_quo ^ SignBit;
					acc_q          <= {34'b0, den_q[48:1]};
				end
			end
			S_WRITE: begin
				res_q.entry_energy <= ent_energy_q;
				res_q.entry_hits   <= hits_q;
				res_q.centroid_x   <= cent_q[0];
				res_q.centroid_y   <= cent_q[1];
				res_q.centroid_z   <= cent_q[2];
			end
			default: ;
		endcase
	end

endmodule
